>>> rtl/ppfl_pkg.sv
package ppfl_pkg;

  localparam int DEF_POOL_SLOTS = 64;

  localparam int SLOT_W = 6;
  localparam int POS_W  = 32;
  localparam int LIFE_W = 16;
  localparam int LINK_W = 7;
  localparam int CNT_W  = 7;
  localparam int KIND_W = 2;

  localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

  localparam logic REQ_CREATE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

endpackage

>>> rtl/particle_pool_free_list_unit.sv
// Create: the result is registered from S_CRE once the output register is free.
// Tick: a start state, then the scan state steps over each free slot below the highest live
//   slot, and each live slot passes S_TSCAN, S_TX and S_TY (one shared 32-bit adder does x then y);
//   an empty pool gives a single empty result, and each result holds while out_ready is low.
// A new request is taken only in idle; the output register lets it in while a result waits.
// Synchronous active-low reset: all slots free, free list in index order, no live slots;
//   flip-flop valid bits stand in for the reset contents of the slot stores.
module particle_pool_free_list_unit
  import ppfl_pkg::*;
#(
  parameter int POOL_SLOTS = DEF_POOL_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_req_type,
  input  logic signed [POS_W-1:0]  in_start_x,
  input  logic signed [POS_W-1:0]  in_start_y,
  input  logic signed [POS_W-1:0]  in_vel_x,
  input  logic signed [POS_W-1:0]  in_vel_y,
  input  logic [LIFE_W-1:0]        in_lifetime,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [KIND_W-1:0]        out_kind,
  output logic                     out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic                     out_expired,
  output logic [CNT_W-1:0]         out_free_count,
  output logic                     out_last
);

  localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [LINK_W-1:0] POOL_LINK = LINK_W'(POOL_SLOTS);
  localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_SLOTS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CRE    = 3'd1;
  localparam logic [2:0] S_TSTART = 3'd2;
  localparam logic [2:0] S_TSCAN  = 3'd3;
  localparam logic [2:0] S_TX     = 3'd4;
  localparam logic [2:0] S_TY     = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic [POOL_SLOTS-1:0]   live_r, live_nxt;
  logic [POOL_SLOTS-1:0]   link_vld_r, link_vld_nxt;
  logic [LINK_W-1:0]       free_head_r, free_head_nxt;
  logic [CNT_W-1:0]        free_total_r, free_total_nxt;
  logic [POS_W-1:0]        sum_x_r, sum_x_nxt;

  logic [POS_W-1:0]        req_x_r, req_y_r, req_vx_r, req_vy_r;
  logic [LIFE_W-1:0]       req_life_r;

  logic                    out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic                    out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]       out_slot_r, out_slot_nxt;
  logic [POS_W-1:0]        out_pos_x_r, out_pos_x_nxt;
  logic [POS_W-1:0]        out_pos_y_r, out_pos_y_nxt;
  logic                    out_expired_r, out_expired_nxt;
  logic [CNT_W-1:0]        out_free_r, out_free_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [POS_W-1:0]        pos_x_mem [POOL_SLOTS];
  logic [POS_W-1:0]        pos_y_mem [POOL_SLOTS];
  logic [POS_W-1:0]        vel_x_mem [POOL_SLOTS];
  logic [POS_W-1:0]        vel_y_mem [POOL_SLOTS];
  logic [LIFE_W-1:0]       frames_mem [POOL_SLOTS];
  logic [LINK_W-1:0]       link_mem [POOL_SLOTS];

  logic [POS_W-1:0]        pos_x_rd_r, pos_y_rd_r, vel_x_rd_r, vel_y_rd_r;
  logic [LIFE_W-1:0]       frames_rd_r;
  logic [LINK_W-1:0]       link_rd_r;

  logic                    st_we, vel_we, link_we;
  logic [IW-1:0]           st_addr, link_waddr, link_raddr;
  logic [POS_W-1:0]        st_px, st_py;
  logic [LIFE_W-1:0]       st_fr;
  logic [LINK_W-1:0]       link_wdata;

  logic [POS_W-1:0]        add_a, add_b, add_sum;
  logic [LIFE_W-1:0]       frames_dec;
  logic [LINK_W-1:0]       link_dflt, link_raw;
  logic [POOL_SLOTS-1:0]   above;
  logic                    more_live;
  logic                    out_free;
  logic                    head_null;
  logic [IW-1:0]           head_idx;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign head_null = (free_head_r >= POOL_LINK);
  assign head_idx  = free_head_r[IW-1:0];

  assign add_a   = (state_r == S_TX) ? pos_x_rd_r : pos_y_rd_r;
  assign add_b   = (state_r == S_TX) ? vel_x_rd_r : vel_y_rd_r;
  assign add_sum = add_a + add_b;

  assign frames_dec = frames_rd_r - LIFE_W'(1);
  assign link_dflt  = ((free_head_r + LINK_W'(1)) < POOL_LINK) ?
                      (free_head_r + LINK_W'(1)) : NULL_LINK;
  assign link_raw   = link_vld_r[head_idx] ? link_rd_r : link_dflt;
  assign link_raddr = head_idx;

  always_comb begin
    for (int j = 0; j < POOL_SLOTS; j++) begin
      above[j] = (IW'(j) > idx_r);
    end
    more_live = |(live_r & above);
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    live_nxt        = live_r;
    link_vld_nxt    = link_vld_r;
    free_head_nxt   = free_head_r;
    free_total_nxt  = free_total_r;
    sum_x_nxt       = sum_x_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_slot_nxt    = out_slot_r;
    out_pos_x_nxt   = out_pos_x_r;
    out_pos_y_nxt   = out_pos_y_r;
    out_expired_nxt = out_expired_r;
    out_free_nxt    = out_free_r;
    out_last_nxt    = out_last_r;
    st_we           = 1'b0;
    vel_we          = 1'b0;
    link_we         = 1'b0;
    st_addr         = idx_r;
    st_px           = add_sum;
    st_py           = add_sum;
    st_fr           = frames_dec;
    link_waddr      = idx_r;
    link_wdata      = free_head_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_req_type == REQ_TICK) ? S_TSTART : S_CRE;
          idx_nxt   = '0;
        end
      end
      S_CRE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_CREATE;
          out_expired_nxt = 1'b0;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
          if (head_null) begin
            out_status_nxt = STATUS_FULL;
            out_slot_nxt   = '0;
            out_pos_x_nxt  = '0;
            out_pos_y_nxt  = '0;
            out_free_nxt   = free_total_r;
          end else begin
            st_we    = 1'b1;
            vel_we   = 1'b1;
            st_addr  = head_idx;
            st_px    = req_x_r;
            st_py    = req_y_r;
            st_fr    = (req_life_r == '0) ? LIFE_W'(1) : req_life_r;
            live_nxt[head_idx] = 1'b1;
            free_head_nxt  = (link_raw >= POOL_LINK) ? NULL_LINK : link_raw;
            free_total_nxt = (free_total_r != '0) ? free_total_r - CNT_W'(1) : free_total_r;
            out_status_nxt = STATUS_OK;
            out_slot_nxt   = SLOT_W'(free_head_r);
            out_pos_x_nxt  = req_x_r;
            out_pos_y_nxt  = req_y_r;
            out_free_nxt   = free_total_nxt;
          end
        end
      end
      S_TSTART: begin
        if (live_r == '0) begin
          if (out_free) begin
            out_valid_nxt   = 1'b1;
            out_kind_nxt    = KIND_EMPTY;
            out_status_nxt  = STATUS_OK;
            out_slot_nxt    = '0;
            out_pos_x_nxt   = '0;
            out_pos_y_nxt   = '0;
            out_expired_nxt = 1'b0;
            out_free_nxt    = free_total_r;
            out_last_nxt    = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          state_nxt = S_TSCAN;
        end
      end
      S_TSCAN: begin
        if (live_r[idx_r]) begin
          state_nxt = S_TX;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_TX: begin
        sum_x_nxt = add_sum;
        state_nxt = S_TY;
      end
      S_TY: begin
        if (out_free) begin
          st_we = 1'b1;
          st_px = sum_x_r;
          st_py = add_sum;
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_UPDATE;
          out_status_nxt  = STATUS_OK;
          out_slot_nxt    = SLOT_W'(idx_r);
          out_pos_x_nxt   = sum_x_r;
          out_pos_y_nxt   = add_sum;
          out_expired_nxt = (frames_dec == '0);
          out_last_nxt    = !more_live;
          if (frames_dec == '0) begin
            link_we              = 1'b1;
            link_vld_nxt[idx_r]  = 1'b1;
            live_nxt[idx_r]      = 1'b0;
            free_head_nxt        = LINK_W'(idx_r);
            free_total_nxt       = (free_total_r < POOL_CNT) ?
                                   free_total_r + CNT_W'(1) : free_total_r;
          end
          out_free_nxt = free_total_nxt;
          if (more_live) begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_TSCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      live_r       <= '0;
      link_vld_r   <= '0;
      free_head_r  <= '0;
      free_total_r <= POOL_CNT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      live_r       <= live_nxt;
      link_vld_r   <= link_vld_nxt;
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_x_r       <= sum_x_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_slot_r    <= out_slot_nxt;
    out_pos_x_r   <= out_pos_x_nxt;
    out_pos_y_r   <= out_pos_y_nxt;
    out_expired_r <= out_expired_nxt;
    out_free_r    <= out_free_nxt;
    out_last_r    <= out_last_nxt;
    if (in_valid && in_ready) begin
      req_x_r    <= in_start_x;
      req_y_r    <= in_start_y;
      req_vx_r   <= in_vel_x;
      req_vy_r   <= in_vel_y;
      req_life_r <= in_lifetime;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      pos_x_mem[st_addr]  <= st_px;
      pos_y_mem[st_addr]  <= st_py;
      frames_mem[st_addr] <= st_fr;
    end
    pos_x_rd_r  <= pos_x_mem[idx_r];
    pos_y_rd_r  <= pos_y_mem[idx_r];
    frames_rd_r <= frames_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_x_mem[st_addr] <= req_vx_r;
      vel_y_mem[st_addr] <= req_vy_r;
    end
    vel_x_rd_r <= vel_x_mem[idx_r];
    vel_y_rd_r <= vel_y_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_r <= link_mem[link_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_expired    = out_expired_r;
  assign out_free_count = out_free_r;
  assign out_last       = out_last_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(live_r) + int'(free_total_r)) == POOL_SLOTS)
    else $error("free count does not match live slots");

  a_full_null_head: assert property (@(posedge clk) disable iff (!rst_n)
    (free_total_r == '0) |-> head_null)
    else $error("pool full but free head is a slot");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CRE || state_r == S_TSTART))
    else $error("accepted request did not start work");

  a_update_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TX) |-> live_r[idx_r])
    else $error("updating a free slot");

endmodule

>>> test/tb_particle_pool_free_list_unit.sv
module tb_particle_pool_free_list_unit;
  import ppfl_pkg::*;

  localparam int POOL = DEF_POOL_SLOTS;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 160;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              expired;
    logic [CNT_W-1:0]  free_count;
    logic              last;
  } pool_result_t;

  class pool_scoreboard;
    logic [POS_W-1:0]  px[64];
    logic [POS_W-1:0]  py[64];
    logic [POS_W-1:0]  vx[64];
    logic [POS_W-1:0]  vy[64];
    logic [LIFE_W-1:0] frames[64];
    logic [LINK_W-1:0] link[64];
    logic [LINK_W-1:0] head;
    logic [CNT_W-1:0]  free_cnt;
    pool_result_t      expected_q[$];
    int                errors;

    function new();
      for (int i = 0; i < 64; i++) begin
        px[i] = '0;
        py[i] = '0;
        vx[i] = '0;
        vy[i] = '0;
        frames[i] = '0;
        link[i] = (i + 1 < POOL) ? LINK_W'(i + 1) : NULL_LINK;
      end
      head = '0;
      free_cnt = CNT_W'(POOL);
      errors = 0;
    endfunction

    function pool_result_t make_result(logic [KIND_W-1:0] kind, logic status,
                                       logic [SLOT_W-1:0] slot, logic [POS_W-1:0] rx,
                                       logic [POS_W-1:0] ry, logic expired, logic last);
      pool_result_t r;
      r.kind = kind;
      r.status = status;
      r.slot = slot;
      r.pos_x = rx;
      r.pos_y = ry;
      r.expired = expired;
      r.free_count = free_cnt;
      r.last = last;
      return r;
    endfunction

    function void note_request(logic req, logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                               logic [POS_W-1:0] svx, logic [POS_W-1:0] svy,
                               logic [LIFE_W-1:0] life);
      int s;
      int n;
      logic expired;
      pool_result_t held;
      if (req == REQ_CREATE) begin
        if (head >= POOL) begin
          expected_q.push_back(make_result(KIND_CREATE, STATUS_FULL, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          s = int'(head);
          head = link[s];
          if (head >= POOL) head = NULL_LINK;
          if (free_cnt > 0) free_cnt--;
          px[s] = sx;
          py[s] = sy;
          vx[s] = svx;
          vy[s] = svy;
          frames[s] = (life == 0) ? LIFE_W'(1) : life;
          expected_q.push_back(make_result(KIND_CREATE, STATUS_OK, SLOT_W'(s), sx, sy,
                                           1'b0, 1'b1));
        end
      end else begin
        n = 0;
        for (int i = 0; i < POOL; i++) begin
          if (frames[i] != 0) begin
            frames[i] = frames[i] - 1'b1;
            px[i] = px[i] + vx[i];
            py[i] = py[i] + vy[i];
            expired = 1'b0;
            if (frames[i] == 0) begin
              link[i] = head;
              head = LINK_W'(i);
              if (free_cnt < POOL) free_cnt++;
              expired = 1'b1;
            end
            if (n > 0) expected_q.push_back(held);
            held = make_result(KIND_UPDATE, STATUS_OK, SLOT_W'(i), px[i], py[i], expired, 1'b0);
            n++;
          end
        end
        if (n == 0) begin
          expected_q.push_back(make_result(KIND_EMPTY, STATUS_OK, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          held.last = 1'b1;
          expected_q.push_back(held);
        end
      end
    endfunction

    task report(string what, logic [63:0] got_v, logic [63:0] exp_v);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got_v, exp_v);
      errors++;
    endtask

    task check_result(pool_result_t got);
      pool_result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected result, slot", 64'(got.slot), '0);
      end else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind) report("kind", 64'(got.kind), 64'(want.kind));
        if (got.status !== want.status) report("status", 64'(got.status), 64'(want.status));
        if (got.slot !== want.slot) report("slot", 64'(got.slot), 64'(want.slot));
        if (got.pos_x !== want.pos_x) report("pos_x", 64'(got.pos_x), 64'(want.pos_x));
        if (got.pos_y !== want.pos_y) report("pos_y", 64'(got.pos_y), 64'(want.pos_y));
        if (got.expired !== want.expired)
          report("expired", 64'(got.expired), 64'(want.expired));
        if (got.free_count !== want.free_count)
          report("free_count", 64'(got.free_count), 64'(want.free_count));
        if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_req_type = REQ_TICK;
  logic signed [POS_W-1:0] in_start_x = '0;
  logic signed [POS_W-1:0] in_start_y = '0;
  logic signed [POS_W-1:0] in_vel_x = '0;
  logic signed [POS_W-1:0] in_vel_y = '0;
  logic [LIFE_W-1:0]       in_lifetime = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [KIND_W-1:0]       out_kind;
  logic                    out_status;
  logic [SLOT_W-1:0]       out_slot;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic                    out_expired;
  logic [CNT_W-1:0]        out_free_count;
  logic                    out_last;

  pool_scoreboard sb;
  pool_result_t   seen_result;
  int             burst_left = 0;
  int             idle_cycles = 0;
  int             rdy_cycle = 0;
  logic [7:0]     rdy_pattern = 8'hB5;

  particle_pool_free_list_unit #(.POOL_SLOTS(POOL)) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_lifetime   (in_lifetime),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_pos_x     (out_pos_x),
    .out_pos_y     (out_pos_y),
    .out_expired   (out_expired),
    .out_free_count(out_free_count),
    .out_last      (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_request(logic req, logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                              logic [POS_W-1:0] svx, logic [POS_W-1:0] svy,
                              logic [LIFE_W-1:0] life);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= req;
    in_start_x <= sx;
    in_start_y <= sy;
    in_vel_x <= svx;
    in_vel_y <= svy;
    in_lifetime <= life;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, sx, sy, svx, svy, life);
  endtask

  task automatic send_tick();
    send_request(REQ_TICK, $urandom, $urandom, $urandom, $urandom, LIFE_W'($urandom));
  endtask

  always @(posedge clk) begin
    rdy_cycle <= rdy_cycle + 1;
    if (rdy_cycle % 48 == 47) begin
      rdy_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      rdy_pattern <= {rdy_pattern[0], rdy_pattern[7:1]};
    end
    out_ready <= rdy_pattern[0];
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_result.kind = out_kind;
      seen_result.status = out_status;
      seen_result.slot = out_slot;
      seen_result.pos_x = out_pos_x;
      seen_result.pos_y = out_pos_y;
      seen_result.expired = out_expired;
      seen_result.free_count = out_free_count;
      seen_result.last = out_last;
      sb.check_result(seen_result);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic              req;
    logic [LIFE_W-1:0] life;
    int                pick;
    bit                fill;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_tick();
    send_request(REQ_CREATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
    send_request(REQ_CREATE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 16'd0);
    send_request(REQ_CREATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000,
                 16'hFFFF);
    send_request(REQ_CREATE, $urandom, $urandom, $urandom, $urandom, 16'd2);
    send_tick();
    send_request(REQ_CREATE, $urandom, $urandom, 32'h8000_0000, 32'h7FFF_FFFF, 16'd3);
    send_request(REQ_CREATE, 32'hFFFF_FFFF, 32'h0, $urandom, $urandom, 16'h8000);
    send_tick();
    send_tick();
    send_request(REQ_CREATE, $urandom, $urandom, $urandom, $urandom, 16'd1);
    send_tick();
    send_tick();
    send_tick();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      fill = (i >= 60 && i < 130);
      pick = $urandom_range(0, 99);
      req = fill ? ((pick < 90) ? REQ_CREATE : REQ_TICK)
                 : ((pick < 55) ? REQ_CREATE : REQ_TICK);
      pick = $urandom_range(0, 99);
      if (fill) life = LIFE_W'($urandom_range(20, 200));
      else if (pick < 60) life = LIFE_W'($urandom_range(1, 6));
      else if (pick < 85) life = LIFE_W'($urandom);
      else life = '0;
      send_request(req, $urandom, $urandom, $urandom, $urandom, life);
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
